// ===== hw/rtl/bsrs_pkg.sv =====
// bsrs_pkg: shared constants, types and codes for the beacon slot round scheduler
// used by bsrs_front, bsrs_back and beacon_slot_round_scheduler; no dependencies
package bsrs_pkg;

   localparam int NUM_BEACONS    = 8;
   localparam int ROUND_MAX      = 16;
   localparam int MANUAL_ENTRIES = 16;

   localparam int BEACON_W = 3;
   localparam int MASK_W   = 8;
   localparam int IDX_W    = (NUM_BEACONS > 1) ? $clog2(NUM_BEACONS) : 1;

   // scores: unsigned fraction of 65536
   localparam int SCORE_W = 17;
   localparam logic [SCORE_W-1:0] SCORE_INIT  = 17'd32768;
   localparam logic [SCORE_W-1:0] SCORE_FLOOR = 17'd1311;
   localparam int SCORE_ONE = 65536;

   // divide by five: multiply by ceil(2^21 / 5), exact for sums below 699050
   localparam int SUM_W      = 19;
   localparam int MULT_W     = 19;
   localparam int PROD_W     = SUM_W + MULT_W;
   localparam int DIV5_SHIFT = 21;
   localparam logic [MULT_W-1:0] DIV5_MULT = 19'd419431;

   localparam int REPEAT_W = 3;
   localparam int BONUS_W  = 4;
   localparam int SLOT_W   = 5;
   localparam int NRDY_W   = $clog2(NUM_BEACONS + 1);
   localparam int REM_W    = 7;
   localparam int CNT_W    = $clog2(ROUND_MAX + 1);
   localparam int MPICK_W  = $clog2(MANUAL_ENTRIES);
   localparam int LEN_W    = 5;
   localparam int ORDER_W  = 48;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // csr port
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_SEL_LSB = 3;
   localparam int CSR_SEL_W   = CSR_ADDR_W - CSR_SEL_LSB;

   localparam logic [CSR_SEL_W-1:0] REG_MANUAL_MODE   = 3'd0;
   localparam logic [CSR_SEL_W-1:0] REG_MANUAL_LENGTH = 3'd1;
   localparam logic [CSR_SEL_W-1:0] REG_MANUAL_ORDER  = 3'd2;
   localparam logic [CSR_SEL_W-1:0] REG_BASE_REPEAT   = 3'd3;
   localparam logic [CSR_SEL_W-1:0] REG_BONUS_SLOTS   = 3'd4;

   typedef struct packed {
      logic                manual_mode;
      logic [LEN_W-1:0]    manual_length;
      logic [ORDER_W-1:0]  manual_order;
      logic [REPEAT_W-1:0] base_repeat;
      logic [BONUS_W-1:0]  bonus_slots;
   } cfg_type;

   typedef enum logic [0:0] {
      OP_REPORT,
      OP_BUILD
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [IDX_W-1:0]       beacon;
      logic                   success;
      logic [NUM_BEACONS-1:0] ready;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REP_MUL,
      ST_REP_WR,
      ST_BUILD,
      ST_BONUS,
      ST_EMIT_AUTO,
      ST_EMIT_MAN,
      ST_EMIT_EMPTY
   } back_state_type;

endpackage

// ===== hw/rtl/bsrs_front.sv =====
// bsrs_front: accepts items, classifies them and queues them for the back end
// depends on bsrs_pkg
module bsrs_front
   import bsrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [BEACON_W-1:0] req_beacon,
   input  logic                req_success,
   input  logic [MASK_W-1:0]   req_ready_mask,
   output logic                q_valid,
   output cmd_type             q_cmd,
   input  logic                q_pop
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               accept;
   logic               keep;
   logic               in_range;
   cmd_type            new_cmd;

   assign busy     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_cmd    = entry_ff[rd_ptr_ff];
   assign accept   = start && !busy;
   assign in_range = ({1'b0, req_beacon} < (BEACON_W+1)'(NUM_BEACONS));

   // reports for beacons out of range are dropped here
   always_comb begin
      new_cmd.op      = req_command ? OP_BUILD : OP_REPORT;
      new_cmd.beacon  = req_beacon[IDX_W-1:0];
      new_cmd.success = req_success;
      new_cmd.ready   = req_ready_mask[NUM_BEACONS-1:0];
      keep            = accept && (req_command || in_range);
   end

   always_comb begin
      wr_ptr_in = keep ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (keep && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!keep && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hw/rtl/bsrs_back.sv =====
// bsrs_back: failure scores, round building and slot emission, one item at a time
// depends on bsrs_pkg; fed by the queue in bsrs_front
module bsrs_back
   import bsrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   output logic                rsp_strobe,
   output logic [BEACON_W-1:0] rsp_slot_beacon,
   output logic                rsp_last,
   output logic                rsp_empty_res
);

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic [SCORE_W-1:0]   score_ff [NUM_BEACONS];
   logic [SCORE_W-1:0]   score_in [NUM_BEACONS];
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [SLOT_W-1:0]    slots_ff [NUM_BEACONS];
   logic [SLOT_W-1:0]    slots_in [NUM_BEACONS];
   logic [BONUS_W-1:0]   bonus_ff [NUM_BEACONS];
   logic [BONUS_W-1:0]   bonus_in [NUM_BEACONS];
   logic [BONUS_W-1:0]   bonus_left_ff, bonus_left_in;
   logic [REM_W-1:0]     remain_ff, remain_in;
   logic [CNT_W-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [IDX_W-1:0]     cursor_ff, cursor_in;
   logic [MANUAL_ENTRIES-1:0] man_vec_ff, man_vec_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [BEACON_W-1:0]  rsp_beacon_ff, rsp_beacon_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic [SUM_W-1:0]     sum;
   logic [SCORE_W-1:0]   quot;
   logic [SCORE_W-1:0]   floored;
   logic [NRDY_W-1:0]    n_ready;
   logic [MANUAL_ENTRIES-1:0] man_vec_new;
   logic [BEACON_W-1:0]  entry;
   logic                 best_valid;
   logic [IDX_W-1:0]     best_idx;
   logic [BONUS_W-1:0]   best_bonus;
   logic [SCORE_W-1:0]   best_score;
   logic [IDX_W-1:0]     auto_pick;
   logic                 auto_hi_found;
   logic [IDX_W-1:0]     auto_hi_pick;
   logic [MPICK_W-1:0]   man_pick;
   logic [MANUAL_ENTRIES-1:0] man_rest;
   logic                 last_slot;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_slot_beacon = rsp_beacon_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_empty_res   = rsp_empty_ff;

   // score update: (4s + target + 2) / 5, floored
   always_comb begin
      sum = SUM_W'({score_ff[cmd_ff.beacon], 2'b00})
          + (cmd_ff.success ? SUM_W'(0) : SUM_W'(SCORE_ONE))
          + SUM_W'(2);
      quot    = prod_ff[DIV5_SHIFT +: SCORE_W];
      floored = (quot < SCORE_FLOOR) ? SCORE_FLOOR : quot;
   end

   // ready count and manual order filtered by readiness
   always_comb begin
      n_ready = '0;
      for (int i = 0; i < NUM_BEACONS; i++) begin
         n_ready = n_ready + NRDY_W'(cmd_ff.ready[i]);
      end
      for (int k = 0; k < MANUAL_ENTRIES; k++) begin
         entry = cfg.manual_order[k*BEACON_W +: BEACON_W];
         man_vec_new[k] = (LEN_W'(k) < cfg.manual_length) && (k < ROUND_MAX)
                       && ({1'b0, entry} < (BEACON_W+1)'(NUM_BEACONS))
                       && cmd_ff.ready[entry[IDX_W-1:0]];
      end
   end

   // bonus target: fewest bonuses, then lowest score, then lowest index
   always_comb begin
      best_valid = 1'b0;
      best_idx   = '0;
      best_bonus = '0;
      best_score = '0;
      for (int i = 0; i < NUM_BEACONS; i++) begin
         if (cmd_ff.ready[i]) begin
            if (!best_valid || (bonus_ff[i] < best_bonus)
                || ((bonus_ff[i] == best_bonus) && (score_ff[i] < best_score))) begin
               best_valid = 1'b1;
               best_idx   = IDX_W'(i);
               best_bonus = bonus_ff[i];
               best_score = score_ff[i];
            end
         end
      end
   end

   // round-robin pick: next beacon at or after the cursor with slots left, wrapping to the lowest
   always_comb begin
      auto_pick     = '0;
      auto_hi_pick  = '0;
      auto_hi_found = 1'b0;
      for (int i = NUM_BEACONS - 1; i >= 0; i--) begin
         if (slots_ff[i] != '0) begin
            auto_pick = IDX_W'(i);
            if (IDX_W'(i) >= cursor_ff) begin
               auto_hi_pick  = IDX_W'(i);
               auto_hi_found = 1'b1;
            end
         end
      end
      if (auto_hi_found) begin
         auto_pick = auto_hi_pick;
      end
      man_pick = '0;
      for (int k = MANUAL_ENTRIES - 1; k >= 0; k--) begin
         if (man_vec_ff[k]) begin
            man_pick = MPICK_W'(k);
         end
      end
      man_rest = man_vec_ff & ~(MANUAL_ENTRIES'(1) << man_pick);
      last_slot = (remain_ff == REM_W'(1)) || (emit_cnt_ff == CNT_W'(ROUND_MAX - 1));
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      score_in      = score_ff;
      prod_in       = prod_ff;
      slots_in      = slots_ff;
      bonus_in      = bonus_ff;
      bonus_left_in = bonus_left_ff;
      remain_in     = remain_ff;
      emit_cnt_in   = emit_cnt_ff;
      cursor_in     = cursor_ff;
      man_vec_in    = man_vec_ff;
      rsp_strobe_in = 1'b0;
      rsp_beacon_in = '0;
      rsp_last_in   = 1'b0;
      rsp_empty_in  = 1'b0;
      q_pop         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               state_in = (q_cmd.op == OP_REPORT) ? ST_REP_MUL : ST_BUILD;
            end
         end
         ST_REP_MUL: begin
            prod_in  = sum * DIV5_MULT;
            state_in = ST_REP_WR;
         end
         ST_REP_WR: begin
            score_in[cmd_ff.beacon] = floored;
            state_in = ST_IDLE;
         end
         ST_BUILD: begin
            emit_cnt_in = '0;
            cursor_in   = '0;
            man_vec_in  = man_vec_new;
            for (int i = 0; i < NUM_BEACONS; i++) begin
               slots_in[i] = cmd_ff.ready[i] ? SLOT_W'(cfg.base_repeat) : '0;
               bonus_in[i] = '0;
            end
            bonus_left_in = (n_ready > NRDY_W'(1)) ? cfg.bonus_slots : '0;
            remain_in     = REM_W'(n_ready) * REM_W'(cfg.base_repeat);
            if (n_ready == '0) begin
               state_in = ST_EMIT_EMPTY;
            end else if (cfg.manual_mode && (man_vec_new != '0)) begin
               state_in = ST_EMIT_MAN;
            end else begin
               state_in = ST_BONUS;
            end
         end
         ST_BONUS: begin
            if ((bonus_left_ff != '0) && best_valid) begin
               bonus_in[best_idx] = bonus_ff[best_idx] + 1'b1;
               slots_in[best_idx] = slots_ff[best_idx] + 1'b1;
               remain_in          = remain_ff + 1'b1;
               bonus_left_in      = bonus_left_ff - 1'b1;
            end else if (remain_ff == '0) begin
               state_in = ST_EMIT_EMPTY;
            end else begin
               state_in = ST_EMIT_AUTO;
            end
         end
         ST_EMIT_AUTO: begin
            rsp_strobe_in       = 1'b1;
            rsp_beacon_in       = BEACON_W'(auto_pick);
            rsp_last_in         = last_slot;
            slots_in[auto_pick] = slots_ff[auto_pick] - 1'b1;
            remain_in           = remain_ff - 1'b1;
            emit_cnt_in         = emit_cnt_ff + 1'b1;
            cursor_in           = auto_pick + 1'b1;
            if (last_slot) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_MAN: begin
            rsp_strobe_in = 1'b1;
            rsp_beacon_in = cfg.manual_order[man_pick*BEACON_W +: BEACON_W];
            rsp_last_in   = (man_rest == '0);
            man_vec_in    = man_rest;
            if (man_rest == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_EMPTY: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = 1'b1;
            rsp_empty_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_BEACONS; i++) begin
            score_ff[i] <= SCORE_INIT;
         end
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         score_ff      <= score_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      prod_ff       <= prod_in;
      slots_ff      <= slots_in;
      bonus_ff      <= bonus_in;
      bonus_left_ff <= bonus_left_in;
      remain_ff     <= remain_in;
      emit_cnt_ff   <= emit_cnt_in;
      cursor_ff     <= cursor_in;
      man_vec_ff    <= man_vec_in;
      rsp_beacon_ff <= rsp_beacon_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_empty_res) |-> (rsp_last && (rsp_slot_beacon == '0)))
      else $error("empty result without last or with a beacon");

   a_round_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_AUTO) |-> (emit_cnt_ff < CNT_W'(ROUND_MAX)))
      else $error("round grew past its cap");

   a_auto_has_slots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_AUTO) |-> (remain_ff != '0))
      else $error("auto emission with no slots left");

   a_manual_has_entries: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_MAN) |-> (man_vec_ff != '0))
      else $error("manual emission with no entries left");

   a_score_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REP_WR) |=> (score_ff[$past(cmd_ff.beacon)] >= SCORE_FLOOR))
      else $error("score fell below the floor");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_valid && (state_ff == ST_IDLE)))
      else $error("queue popped while empty or busy");

endmodule

// ===== hw/rtl/beacon_slot_round_scheduler.sv =====
// beacon_slot_round_scheduler: top level with the csr registers
// depends on bsrs_pkg, bsrs_front and bsrs_back
//
//   channel   | ports                                       | handshake
//   ----------+---------------------------------------------+---------------------------
//   request   | req_command req_beacon req_success          | start high while busy low
//             | req_ready_mask                              |
//   response  | rsp_slot_beacon rsp_last rsp_empty_res      | rsp_strobe, one cycle
//   csr       | psel penable pwrite paddr pwdata prdata     | write when psel, penable,
//             | pready                                      | pwrite, pready all high
//
// a report item passes through the back end as queue pop, multiply and score write
// a build item passes through queue pop and setup, in auto mode then the bonus hand-out
// one bonus slot at a time and its exit, then emission of the slots one by one; each
// slot is registered and shows on the outputs in the cycle after it is formed
// a two-entry queue holds items while the back end works; busy is high when it is full
// reset clears the queue, control state and csr registers and sets every score to one half
module beacon_slot_round_scheduler
   import bsrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [BEACON_W-1:0]   req_beacon,
   input  logic                  req_success,
   input  logic [MASK_W-1:0]     req_ready_mask,
   output logic                  rsp_strobe,
   output logic [BEACON_W-1:0]   rsp_slot_beacon,
   output logic                  rsp_last,
   output logic                  rsp_empty_res,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type              cfg_ff, cfg_in;
   logic                 csr_write;
   logic [CSR_SEL_W-1:0] csr_sel;
   logic                 q_valid;
   cmd_type              q_cmd;
   logic                 q_pop;

   assign pready    = 1'b1;
   assign csr_sel   = paddr[CSR_ADDR_W-1:CSR_SEL_LSB];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (csr_sel)
         REG_MANUAL_MODE: begin
            prdata = CSR_DATA_W'(cfg_ff.manual_mode);
            if (csr_write) cfg_in.manual_mode = pwdata[0];
         end
         REG_MANUAL_LENGTH: begin
            prdata = CSR_DATA_W'(cfg_ff.manual_length);
            if (csr_write) cfg_in.manual_length = pwdata[LEN_W-1:0];
         end
         REG_MANUAL_ORDER: begin
            prdata = CSR_DATA_W'(cfg_ff.manual_order);
            if (csr_write) cfg_in.manual_order = pwdata[ORDER_W-1:0];
         end
         REG_BASE_REPEAT: begin
            prdata = CSR_DATA_W'(cfg_ff.base_repeat);
            if (csr_write) cfg_in.base_repeat = pwdata[REPEAT_W-1:0];
         end
         REG_BONUS_SLOTS: begin
            prdata = CSR_DATA_W'(cfg_ff.bonus_slots);
            if (csr_write) cfg_in.bonus_slots = pwdata[BONUS_W-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manual_mode   <= 1'b0;
         cfg_ff.manual_length <= '0;
         cfg_ff.manual_order  <= '0;
         cfg_ff.base_repeat   <= REPEAT_W'(1);
         cfg_ff.bonus_slots   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bsrs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_beacon     (req_beacon),
      .req_success    (req_success),
      .req_ready_mask (req_ready_mask),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop)
   );

   bsrs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_slot_beacon (rsp_slot_beacon),
      .rsp_last        (rsp_last),
      .rsp_empty_res   (rsp_empty_res)
   );

endmodule
